FILE: design/swld_pkg.sv
// shared types, constants and stop-word tables for the stop-word language detector
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package swld_pkg;

	// counter and field sizes
	localparam int COUNT_WIDTH = 16;
	localparam int FIELD_WIDTH = 16;
	localparam int EXT_WIDTH   = (COUNT_WIDTH > FIELD_WIDTH) ? COUNT_WIDTH : FIELD_WIDTH;
	localparam logic [FIELD_WIDTH-1:0] FIELD_MAX = {FIELD_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	// word table geometry
	localparam int WORDS      = 13;
	localparam int MAX_WORD   = 5;
	localparam int HIST_DEPTH = MAX_WORD - 1;
	localparam int HIT_WIDTH  = $clog2(WORDS + 1);

	// tdata widths
	localparam int OUT_BITS  = 2 + 2 * FIELD_WIDTH;
	localparam int OUT_WIDTH = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [1:0] {
		LANG_NONE       = 2'd0,
		LANG_ENGLISH    = 2'd1,
		LANG_PORTUGUESE = 2'd2
	} lang_t;

	typedef logic [MAX_WORD-1:0][7:0] window_t; // [MAX_WORD-1] is the newest byte

	// b[0] is the first byte of the word, unused bytes are zero
	typedef struct packed {
		logic [2:0]               len;
		logic [MAX_WORD-1:0][7:0] b;
	} word_t;

	typedef struct packed {
		logic [HIT_WIDTH-1:0] en;
		logic [HIT_WIDTH-1:0] pt;
	} hits_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] en;
		logic [COUNT_WIDTH-1:0] pt;
	} tally_t;

	localparam word_t EN_WORDS [WORDS] = '{
		'{len: 3'd3, b: {8'h00, 8'h00, "e", "h", "t"}},
		'{len: 3'd2, b: {8'h00, 8'h00, 8'h00, "e", "b"}},
		'{len: 3'd2, b: {8'h00, 8'h00, 8'h00, "o", "t"}},
		'{len: 3'd2, b: {8'h00, 8'h00, 8'h00, "f", "o"}},
		'{len: 3'd3, b: {8'h00, 8'h00, "d", "n", "a"}},
		'{len: 3'd3, b: {8'h00, 8'h00, "r", "o", "f"}},
		'{len: 3'd2, b: {8'h00, 8'h00, 8'h00, "n", "i"}},
		'{len: 3'd4, b: {8'h00, "t", "a", "h", "t"}},
		'{len: 3'd4, b: {8'h00, "e", "v", "a", "h"}},
		'{len: 3'd1, b: {8'h00, 8'h00, 8'h00, 8'h00, "I"}},
		'{len: 3'd2, b: {8'h00, 8'h00, 8'h00, "t", "i"}},
		'{len: 3'd3, b: {8'h00, 8'h00, "t", "o", "n"}},
		'{len: 3'd2, b: {8'h00, 8'h00, 8'h00, "n", "o"}}
	};

	// portuguese words in utf-8 byte form
	localparam word_t PT_WORDS [WORDS] = '{
		'{len: 3'd3, b: {8'h00, 8'h00, "e", "u", "q"}},
		'{len: 3'd4, b: {8'h00, "o", 8'hA3, 8'hC3, "n"}},
		'{len: 3'd2, b: {8'h00, 8'h00, 8'h00, "e", "d"}},
		'{len: 3'd2, b: {8'h00, 8'h00, 8'h00, "m", "u"}},
		'{len: 3'd4, b: {8'h00, "a", "r", "a", "p"}},
		'{len: 3'd2, b: {8'h00, 8'h00, 8'h00, "e", "s"}},
		'{len: 3'd3, b: {8'h00, 8'h00, "a", "m", "u"}},
		'{len: 3'd5, b: {8'hA1, 8'hC3, "t", "s", "e"}},
		'{len: 3'd3, b: {8'h00, 8'h00, "m", "o", "c"}},
		'{len: 3'd2, b: {8'h00, 8'h00, 8'h00, "o", "d"}},
		'{len: 3'd3, b: {8'h00, 8'h00, "r", "o", "p"}},
		'{len: 3'd3, b: {8'h00, 8'h00, "s", "a", "m"}},
		'{len: 3'd2, b: {8'h00, 8'h00, 8'h00, 8'hA9, 8'hC3}}
	};

	// number of words of one table that end at the newest byte of the window
	function automatic logic [HIT_WIDTH-1:0] count_hits(input logic pt, input window_t win);
		word_t                w;
		logic                 ok;
		logic [HIT_WIDTH-1:0] total;
		total = '0;
		for (int n = 0; n < WORDS; n++) begin
			w  = pt ? PT_WORDS[n] : EN_WORDS[n];
			ok = (w.len != 3'd0);
			for (int k = 0; k < MAX_WORD; k++) begin
				if (k < int'(w.len)) begin
					if (w.b[k] != win[MAX_WORD - int'(w.len) + k]) begin
						ok = 1'b0;
					end
				end
			end
			if (ok) begin
				total = total + HIT_WIDTH'(1);
			end
		end
		return total;
	endfunction

	// limit a count to the reported field width
	function automatic logic [FIELD_WIDTH-1:0] clip_count(input logic [COUNT_WIDTH-1:0] c);
		logic [EXT_WIDTH-1:0] e;
		e = EXT_WIDTH'(c);
		if (e > EXT_WIDTH'(FIELD_MAX)) begin
			return FIELD_MAX;
		end
		return e[FIELD_WIDTH-1:0];
	endfunction

endpackage

FILE: design/swld_match.sv
// parallel stop-word matcher: counts english and portuguese words ending at the newest byte
// depends on swld_pkg for the word tables and count_hits
`timescale 1ns / 1ps

module swld_match
	import swld_pkg::*;
(
	input  window_t win,
	output hits_t   hits
);

	always_comb begin
		hits.en = count_hits(1'b0, win);
		hits.pt = count_hits(1'b1, win);
	end

endmodule

FILE: design/swld_acc.sv
// byte history and saturating per-language counters of the stop-word detector
// depends on swld_pkg and swld_match
`timescale 1ns / 1ps

module swld_acc
	import swld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] text_byte,
	input  logic       last,
	output tally_t     tally_next
);

	logic [HIST_DEPTH-1:0][7:0] hist_q; // [0] is the most recent byte
	tally_t                     tally_q;
	window_t                    win;
	hits_t                      hits;

	always_comb begin
		win[MAX_WORD-1] = text_byte;
		for (int k = 0; k < HIST_DEPTH; k++) begin
			win[HIST_DEPTH-1-k] = hist_q[k];
		end
	end

	swld_match u_match (
		.win  (win),
		.hits (hits)
	);

	function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] c,
	                                                  input logic [HIT_WIDTH-1:0] h);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, c} + (COUNT_WIDTH + 1)'(h);
		return s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
	endfunction

	always_comb begin
		tally_next.en = sat_add(tally_q.en, hits.en);
		tally_next.pt = sat_add(tally_q.pt, hits.pt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			tally_q <= '0;
		end else if (step) begin
			if (last) begin
				hist_q  <= '0;
				tally_q <= '0;
			end else begin
				hist_q  <= {hist_q[HIST_DEPTH-2:0], text_byte};
				tally_q <= tally_next;
			end
		end
	end

endmodule

FILE: design/stop_word_language_detector.sv
// top level of the stop-word language detector: input stage, counters and result register
// depends on swld_pkg and swld_acc (which holds swld_match)
`timescale 1ns / 1ps

// stop-word language detector. text arrives one byte per input transaction, the
// final byte of a text flagged by s_tlast. every byte is compared at once against
// 13 english and 13 portuguese stop words (portuguese in utf-8 bytes); each word
// that ends on the byte adds one to its language's saturating counter. words may
// overlap and may sit inside longer words, matching is case sensitive. on the
// final byte one output transaction carries the decision (0 no hit, 1 english
// leads, 2 portuguese leads or tie) and both counts, and the counts and the
// four-byte history clear so no match spans two texts. throughput is one byte
// per clock: the input register feeds the matcher and counter update, which
// feeds the output register, and a byte is taken every cycle unless a result is
// held in the output register while m_tready is low and another final byte is
// waiting.

module stop_word_language_detector
	import swld_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // [7:0] text_byte
	input  logic                 s_tlast,  // end_of_text
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_WIDTH-1:0] m_tdata   // [1:0] language, [17:2] english_hits,
	                                       // [33:18] portuguese_hits, rest zero
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result register
	logic                   m_valid_q;
	lang_t                  lang_q;
	logic [FIELD_WIDTH-1:0] en_hits_q;
	logic [FIELD_WIDTH-1:0] pt_hits_q;

	logic   consume;
	tally_t tally_next;
	lang_t  lang_next;

	// a non-final byte never needs the result register, a final one needs it free
	assign consume  = valid_s1 && (!last_s1 || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	swld_acc u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (consume),
		.text_byte  (byte_s1),
		.last       (last_s1),
		.tally_next (tally_next)
	);

	// decision on the full-width counts, nonzero ties go to portuguese
	always_comb begin
		if (tally_next.en == '0 && tally_next.pt == '0) begin
			lang_next = LANG_NONE;
		end else if (tally_next.en > tally_next.pt) begin
			lang_next = LANG_ENGLISH;
		end else begin
			lang_next = LANG_PORTUGUESE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (consume && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			lang_q    <= lang_next;
			en_hits_q <= clip_count(tally_next.en);
			pt_hits_q <= clip_count(tally_next.pt);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_WIDTH'({pt_hits_q, en_hits_q, lang_q});

endmodule
